@@ design/rgbwf_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbwf_pkg
// Shared types and constants for the RGBW LED fader with cube gamma.
// ----------------------------------------------------------------------------
package rgbwf_pkg;

  localparam int LEVEL_MAX_DEF = 1023;
  localparam int DUTY_W        = 10;
  localparam int TARGET_W      = 10;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 10;

  typedef enum logic [1:0] {
    CH_RED   = 2'd0,
    CH_GREEN = 2'd1,
    CH_BLUE  = 2'd2,
    CH_WHITE = 2'd3
  } chan_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYCLE_MODE   = 3'd0,
    REG_TARGET_RED   = 3'd1,
    REG_TARGET_GREEN = 3'd2,
    REG_TARGET_BLUE  = 3'd3,
    REG_TARGET_WHITE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic  latch;
    logic  update;
    logic  issue;
    chan_t ch;
    logic  advance;
    logic  load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } sts_t;

endpackage

@@ design/rgbwf_gamma.sv @@
// ----------------------------------------------------------------------------
// rgbwf_gamma
// Pipelined active-low cube gamma: duty = floor((MAX-level)^3 / MAX^2).
// ----------------------------------------------------------------------------
module rgbwf_gamma
  import rgbwf_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF,
  localparam int LW = $clog2(LEVEL_MAX + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          issue_valid,
  input  chan_t         issue_ch,
  input  logic [LW-1:0] issue_level,
  output logic          wr_valid,
  output chan_t         wr_ch,
  output logic [LW-1:0] wr_duty,
  output logic          busy
);

  localparam int SQ_W   = 2 * LW;
  localparam int CUBE_W = 3 * LW;
  localparam int RW     = LW + 2;
  localparam int PROD_W = CUBE_W + RW;
  localparam longint unsigned RECIP_FULL =
    (longint'(1) << CUBE_W) / (longint'(LEVEL_MAX) * longint'(LEVEL_MAX));
  localparam logic [SQ_W-1:0]   DIVISOR = SQ_W'(LEVEL_MAX * LEVEL_MAX);
  localparam logic [RW-1:0]     RECIP   = RW'(RECIP_FULL);
  localparam logic [LW-1:0]     LMAX    = LW'(LEVEL_MAX);

  logic [5:1]        v_r;
  chan_t             ch1_r, ch2_r, ch3_r, ch4_r, ch5_r;
  logic [LW-1:0]     inv_r, inv2_r;
  logic [SQ_W-1:0]   sq_r;
  logic [CUBE_W-1:0] cube_r, cube4_r, cube5_r, qd_r, rem;
  logic [PROD_W-1:0] prod_r;
  logic [LW-1:0]     q0_r;
  logic [LW-1:0]     inv;

  assign inv = (issue_level > LMAX) ? '0 : LMAX - issue_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:1], issue_valid};
    end
  end

  always_ff @(posedge clk) begin
    ch1_r   <= issue_ch;
    inv_r   <= inv;
    ch2_r   <= ch1_r;
    sq_r    <= inv_r * inv_r;
    inv2_r  <= inv_r;
    ch3_r   <= ch2_r;
    cube_r  <= sq_r * inv2_r;
    ch4_r   <= ch3_r;
    prod_r  <= cube_r * RECIP;
    cube4_r <= cube_r;
    ch5_r   <= ch4_r;
    q0_r    <= prod_r[CUBE_W +: LW];
    qd_r    <= prod_r[CUBE_W +: LW] * DIVISOR;
    cube5_r <= cube4_r;
  end

  // reciprocal estimate is low by at most one
  assign rem      = cube5_r - qd_r;
  assign wr_duty  = (rem >= CUBE_W'(DIVISOR)) ? q0_r + LW'(1) : q0_r;
  assign wr_valid = v_r[5];
  assign wr_ch    = ch5_r;
  assign busy     = |v_r;

endmodule

@@ design/rgbwf_dpath.sv @@
// ----------------------------------------------------------------------------
// rgbwf_dpath
// Datapath: config registers, fade levels, color cycle phase, held duties.
// ----------------------------------------------------------------------------
module rgbwf_dpath
  import rgbwf_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_rgb_step,
  input  logic                  in_white_step,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [DUTY_W-1:0]     out_duty_red,
  output logic [DUTY_W-1:0]     out_duty_green,
  output logic [DUTY_W-1:0]     out_duty_blue,
  output logic [DUTY_W-1:0]     out_duty_white
);

  localparam int LW = $clog2(LEVEL_MAX + 1);
  localparam int CW = (LW > TARGET_W) ? LW : TARGET_W;
  localparam logic [LW-1:0] LMAX = LW'(LEVEL_MAX);
  localparam logic [2:0] POS_RED   = 3'd2;
  localparam logic [2:0] POS_GREEN = 3'd1;
  localparam logic [2:0] POS_BLUE  = 3'd0;

  logic                cycle_mode_r;
  logic [TARGET_W-1:0] target_r [4];
  logic [LW-1:0]       level_r  [4];
  logic [LW-1:0]       held_r   [4];
  logic [LW-1:0]       phase_r;
  logic [1:0]          rot_r;
  logic                rgb_r, white_r;
  logic [DUTY_W-1:0]   out_red_r, out_green_r, out_blue_r, out_white_r;

  logic          issue_valid;
  logic [LW-1:0] issue_level;
  logic [2:0]    pos, rel;
  logic          wr_valid;
  chan_t         wr_ch;
  logic [LW-1:0] wr_duty;
  logic          busy;

  function automatic logic [LW-1:0] approach(input logic [LW-1:0] lvl,
                                             input logic [TARGET_W-1:0] tgt);
    logic [CW-1:0] tgt_w;
    logic [LW-1:0] tgt_c;
    tgt_w = CW'(tgt);
    tgt_c = (tgt_w > CW'(LEVEL_MAX)) ? LMAX : LW'(tgt_w);
    if (tgt_c > lvl) begin
      return lvl + LW'(1);
    end else if (tgt_c < lvl) begin
      return lvl - LW'(1);
    end
    return lvl;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cycle_mode_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        target_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CYCLE_MODE:   cycle_mode_r       <= cfg_wdata[0];
        REG_TARGET_RED:   target_r[CH_RED]   <= cfg_wdata;
        REG_TARGET_GREEN: target_r[CH_GREEN] <= cfg_wdata;
        REG_TARGET_BLUE:  target_r[CH_BLUE]  <= cfg_wdata;
        REG_TARGET_WHITE: target_r[CH_WHITE] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rgb_r   <= in_rgb_step;
      white_r <= in_white_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        level_r[i] <= '0;
      end
    end else if (cmd.update) begin
      if (rgb_r && !cycle_mode_r) begin
        level_r[CH_RED]   <= approach(level_r[CH_RED],   target_r[CH_RED]);
        level_r[CH_GREEN] <= approach(level_r[CH_GREEN], target_r[CH_GREEN]);
        level_r[CH_BLUE]  <= approach(level_r[CH_BLUE],  target_r[CH_BLUE]);
      end
      if (white_r) begin
        level_r[CH_WHITE] <= approach(level_r[CH_WHITE], target_r[CH_WHITE]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
      rot_r   <= '0;
    end else if (cmd.advance && rgb_r && cycle_mode_r) begin
      if (phase_r == LMAX) begin
        phase_r <= '0;
        rot_r   <= (rot_r == 2'd2) ? 2'd0 : rot_r + 2'd1;
      end else begin
        phase_r <= phase_r + LW'(1);
      end
    end
  end

  // position of the channel in the blue, green, red order, relative to rotation
  always_comb begin
    unique case (cmd.ch)
      CH_RED:   pos = POS_RED;
      CH_GREEN: pos = POS_GREEN;
      default:  pos = POS_BLUE;
    endcase
    rel = pos + 3'd3 - {1'b0, rot_r};
    if (rel >= 3'd3) begin
      rel = rel - 3'd3;
    end
  end

  always_comb begin
    if (cmd.ch == CH_WHITE) begin
      issue_valid = cmd.issue && white_r;
      issue_level = level_r[CH_WHITE];
    end else begin
      issue_valid = cmd.issue && rgb_r;
      if (!cycle_mode_r) begin
        issue_level = level_r[cmd.ch];
      end else if (rel == 3'd0) begin
        issue_level = '0;
      end else if (rel == 3'd1) begin
        issue_level = LMAX - phase_r;
      end else begin
        issue_level = phase_r;
      end
    end
  end

  rgbwf_gamma #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_gamma (
    .clk         (clk),
    .rst_n       (rst_n),
    .issue_valid (issue_valid),
    .issue_ch    (cmd.ch),
    .issue_level (issue_level),
    .wr_valid    (wr_valid),
    .wr_ch       (wr_ch),
    .wr_duty     (wr_duty),
    .busy        (busy)
  );

  assign sts.pipe_busy = busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        held_r[i] <= LMAX;
      end
    end else if (wr_valid) begin
      held_r[wr_ch] <= wr_duty;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_red_r   <= DUTY_W'(held_r[CH_RED]);
      out_green_r <= DUTY_W'(held_r[CH_GREEN]);
      out_blue_r  <= DUTY_W'(held_r[CH_BLUE]);
      out_white_r <= DUTY_W'(held_r[CH_WHITE]);
    end
  end

  assign out_duty_red   = out_red_r;
  assign out_duty_green = out_green_r;
  assign out_duty_blue  = out_blue_r;
  assign out_duty_white = out_white_r;

endmodule

@@ design/rgbwf_ctrl.sv @@
// ----------------------------------------------------------------------------
// rgbwf_ctrl
// Controller: sequences one tick through update, gamma issue and output.
// ----------------------------------------------------------------------------
module rgbwf_ctrl
  import rgbwf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  chan_t  ch_r, ch_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd          = '0;
    cmd.latch    = (state_r == ST_IDLE) && in_valid;
    cmd.update   = (state_r == ST_UPDATE);
    cmd.issue    = (state_r == ST_ISSUE);
    cmd.ch       = ch_r;
    cmd.advance  = (state_r == ST_ISSUE) && (ch_r == CH_WHITE);
    cmd.load_out = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_nxt = ST_ISSUE;
        ch_nxt    = CH_RED;
      end
      ST_ISSUE: begin
        ch_nxt = chan_t'(ch_r + 2'd1);
        if (ch_r == CH_WHITE) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd.load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= CH_RED;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/rgbw_led_fader_gamma_core.sv @@
// ----------------------------------------------------------------------------
// rgbw_led_fader_gamma_core
// RGBW LED fader with rotating color crossfade and active-low cube gamma.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   in_rgb_step, in_white_step
//   out      output     out_valid / out_stall out_duty_red/green/blue/white
//   cfg      input      cfg_we                cfg_index, cfg_wdata
//
// The next tick is accepted once the previous result has been loaded, even
// while that result is stalled. Each tick runs an update step, issues the
// four channels one per cycle into the shared five-stage cube gamma
// pipeline, drains it and loads the output. Synchronous active-low reset;
// held duties reset to dark, the output registers are not. A stalled result
// blocks loading the next result only, not acceptance of the next tick.
// ----------------------------------------------------------------------------
module rgbw_led_fader_gamma_core
  import rgbwf_pkg::*;
#(
  parameter int LEVEL_MAX = LEVEL_MAX_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_rgb_step,
  input  logic                  in_white_step,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DUTY_W-1:0]     out_duty_red,
  output logic [DUTY_W-1:0]     out_duty_green,
  output logic [DUTY_W-1:0]     out_duty_blue,
  output logic [DUTY_W-1:0]     out_duty_white
);

  cmd_t cmd;
  sts_t sts;

  rgbwf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  rgbwf_dpath #(
    .LEVEL_MAX (LEVEL_MAX)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_rgb_step    (in_rgb_step),
    .in_white_step  (in_white_step),
    .cmd            (cmd),
    .sts            (sts),
    .out_duty_red   (out_duty_red),
    .out_duty_green (out_duty_green),
    .out_duty_blue  (out_duty_blue),
    .out_duty_white (out_duty_white)
  );

endmodule
